/* rtl/core/tjqd_pkg.sv */
// ----------------------------------------------------------------------------
// tjqd_pkg
// Shared types and codes for the typed job queue dispatcher: result status
// codes, job class numbers and the field widths of the ports.
// ----------------------------------------------------------------------------
`default_nettype none

package tjqd_pkg;

	// Width of the handle, class and preference fields on the ports
	localparam int HANDLE_W = 16;
	localparam int CLS_W    = 3;
	localparam int FLAG_W   = 5;
	localparam int NUM_PREF = 5;

	// Result status of one word
	typedef enum logic [2:0] {
		ST_QUEUED = 3'd0,
		ST_NULL   = 3'd1,
		ST_FULL   = 3'd2,
		ST_GRANT  = 3'd3,
		ST_NOJOB  = 3'd4
	} status_t;

	// Input function codes
	typedef enum logic {
		FN_SUBMIT  = 1'b0,
		FN_REQUEST = 1'b1
	} func_t;

	// Job classes (queue numbers)
	typedef logic [CLS_W-1:0] cls_t;
	localparam cls_t CLS_IMPORTANT = 3'd0;
	localparam cls_t CLS_MISC      = 3'd5;

endpackage

`default_nettype wire

/* rtl/core/typed_job_queue_dispatcher.sv */
// ----------------------------------------------------------------------------
// typed_job_queue_dispatcher
// Six FIFO queues of job handles, one per job class, kept in one shared
// synchronous memory, with a submit / request front end and a result register.
// ----------------------------------------------------------------------------
// The block takes one word per cycle when not stalled and returns one result
// word for each, through the queue memory read register (stage 1) and then
// the result register. The queue pointers and occupancy counts sit in
// flip-flops and are updated at acceptance, so a submit and a following
// request to the same queue need no interlock: the memory write of an entry
// always lands at an earlier edge than its read. The input stalls only while
// a finished result waits in the output register and the stage behind it is
// also full. A submit goes to the lowest set class flag (misc if none); a
// request serves the important queue first, then the five preferences in
// order. There is no clearing pass after reset; the queue memory holds
// nothing meaningful until entries are pushed.
`default_nettype none

module typed_job_queue_dispatcher #(
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16,
	parameter int NUM_CLASSES = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            func,
	input  wire logic [tjqd_pkg::HANDLE_W-1:0]   job_handle,
	input  wire logic [tjqd_pkg::FLAG_W-1:0]     class_flags,
	input  wire logic [tjqd_pkg::CLS_W-1:0]      pref_first,
	input  wire logic [tjqd_pkg::CLS_W-1:0]      pref_second,
	input  wire logic [tjqd_pkg::CLS_W-1:0]      pref_third,
	input  wire logic [tjqd_pkg::CLS_W-1:0]      pref_fourth,
	input  wire logic [tjqd_pkg::CLS_W-1:0]      pref_fifth,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output tjqd_pkg::status_t                    status,
	output logic [tjqd_pkg::HANDLE_W-1:0]        granted_handle,
	output logic [tjqd_pkg::CLS_W-1:0]           queue_used
);
	import tjqd_pkg::*;

	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int ADDR_W    = CLS_W + PTR_W;
	localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Queue bookkeeping
	ptr_t heads_q  [NUM_CLASSES];
	ptr_t tails_q  [NUM_CLASSES];
	cnt_t counts_q [NUM_CLASSES];

	// Shared queue memory, address {class, pointer}
	logic [STORE_W-1:0] mem [MEM_DEPTH];
	logic [STORE_W-1:0] rdata_s1;

	// Stage 1: waiting for memory read data
	logic    valid_s1;
	status_t status_s1;
	cls_t    used_s1;
	logic    grant_s1;

	// Output register
	logic                out_valid_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] handle_q;
	cls_t                used_q;

	// Handshake
	logic in_accept;
	logic adv_s1;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	function automatic ptr_t wrap_next(input ptr_t p);
		wrap_next = (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	// Occupancy flags
	logic [NUM_CLASSES-1:0] nonempty;
	logic [NUM_CLASSES-1:0] full;
	always_comb begin
		for (int q = 0; q < NUM_CLASSES; q++) begin
			nonempty[q] = (counts_q[q] != '0);
			full[q]     = (counts_q[q] == cnt_t'(QUEUE_DEPTH));
		end
	end

	// Submit: pick the class of the lowest set flag
	logic [STORE_W-1:0] sub_handle;
	logic               sub_null;
	cls_t               sub_cls;
	always_comb begin
		sub_handle = job_handle[STORE_W-1:0];
		sub_null   = (sub_handle == '0);
		sub_cls    = CLS_MISC;
		for (int b = FLAG_W - 1; b >= 0; b--) begin
			if (class_flags[b]) begin
				sub_cls = cls_t'(b);
			end
		end
	end

	// Request: important first, then the preference list
	cls_t prefs [NUM_PREF];
	logic req_found;
	cls_t req_cls;
	always_comb begin
		prefs[0]  = pref_first;
		prefs[1]  = pref_second;
		prefs[2]  = pref_third;
		prefs[3]  = pref_fourth;
		prefs[4]  = pref_fifth;
		req_found = nonempty[CLS_IMPORTANT];
		req_cls   = CLS_IMPORTANT;
		for (int i = 0; i < NUM_PREF; i++) begin
			if (!req_found && (prefs[i] < cls_t'(NUM_CLASSES)) && nonempty[prefs[i]]) begin
				req_found = 1'b1;
				req_cls   = prefs[i];
			end
		end
	end

	// Decision for the accepted word
	logic    do_push;
	logic    do_pop;
	status_t dec_status;
	cls_t    dec_used;
	always_comb begin
		do_push    = 1'b0;
		do_pop     = 1'b0;
		dec_status = ST_NOJOB;
		dec_used   = CLS_IMPORTANT;
		case (func_t'(func))
			FN_SUBMIT: begin
				if (sub_null) begin
					dec_status = ST_NULL;
				end else if (full[sub_cls]) begin
					dec_status = ST_FULL;
					dec_used   = sub_cls;
				end else begin
					dec_status = ST_QUEUED;
					dec_used   = sub_cls;
					do_push    = in_accept;
				end
			end
			FN_REQUEST: begin
				if (req_found) begin
					dec_status = ST_GRANT;
					dec_used   = req_cls;
					do_pop     = in_accept;
				end
			end
			default: begin
				dec_status = ST_NOJOB;
			end
		endcase
	end

	// Queue memory: one write and one registered read port
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	assign waddr = {sub_cls, tails_q[sub_cls]};
	assign raddr = {req_cls, heads_q[req_cls]};

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[waddr] <= sub_handle;
		end
		if (do_pop) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_CLASSES; q++) begin
				heads_q[q]  <= '0;
				tails_q[q]  <= '0;
				counts_q[q] <= '0;
			end
		end else begin
			if (do_push) begin
				tails_q[sub_cls]  <= wrap_next(tails_q[sub_cls]);
				counts_q[sub_cls] <= counts_q[sub_cls] + cnt_t'(1);
			end
			if (do_pop) begin
				heads_q[req_cls]  <= wrap_next(heads_q[req_cls]);
				counts_q[req_cls] <= counts_q[req_cls] - cnt_t'(1);
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1 <= dec_status;
			used_s1   <= dec_used;
			grant_s1  <= do_pop;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= status_s1;
			used_q   <= used_s1;
			handle_q <= grant_s1 ? HANDLE_W'(rdata_s1) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign granted_handle = handle_q;
	assign queue_used     = used_q;

`ifndef SYNTHESIS
	// The input stalls only behind a held stage 1 word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// An accepted word always occupies stage 1 next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted word lost before stage 1");

	// Only non-null handles are ever stored, so a grant never returns zero
	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_GRANT) |-> (handle_q != '0))
		else $error("grant returned a null handle");

	// A handle is shown only on a grant
	a_handle_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_GRANT) |-> (handle_q == '0))
		else $error("handle shown without a grant");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed job queue dispatcher. A short directed
// run covers each class, null handles, none and repeated-important
// preferences and the empty cases. Phased random traffic then fills, drains
// and mixes the six class queues until they overflow and run dry. Every
// result word is checked in order against a cycle-free model of the queues.
// ----------------------------------------------------------------------------

module tb_top;
	import tjqd_pkg::*;

	localparam int QDEPTH       = 16;
	localparam int NCLS         = 6;
	localparam int RANDOM_WORDS = 900;
	localparam cls_t PREF_NONE  = 3'd6;
	localparam cls_t PREF_SPARE = 3'd7;	// unused code, also skipped
	localparam cls_t CLS_IO     = 3'd1;
	localparam cls_t CLS_HUGE   = 3'd2;
	localparam cls_t CLS_GFX    = 3'd3;
	localparam cls_t CLS_TINY   = 3'd4;

	typedef logic [0:NUM_PREF-1][CLS_W-1:0] pref_list_t;

	typedef struct packed {
		func_t               fn;
		logic [HANDLE_W-1:0] handle;
		logic [FLAG_W-1:0]   flags;
		pref_list_t          prefs;
	} job_word_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		cls_t                queue;
	} dispatch_result_t;

	// Model of the class queues plus the results still owed by the block
	class job_queue_tracker;
		logic [HANDLE_W-1:0] class_jobs[NCLS][$];
		dispatch_result_t    owed[$];
		int                  errors;

		// Work out the result of one accepted word
		function void predict(job_word_t w);
			dispatch_result_t r;
			cls_t             q;
			bit               found;
			r.status = ST_QUEUED;
			r.handle = '0;
			r.queue  = CLS_IMPORTANT;
			if (w.fn == FN_SUBMIT) begin
				if (w.handle == '0) begin
					r.status = ST_NULL;
				end else begin
					// lowest set flag wins, misc when none set
					q = CLS_MISC;
					for (int b = FLAG_W - 1; b >= 0; b--)
						if (w.flags[b]) q = cls_t'(b);
					r.queue = q;
					if (class_jobs[q].size() >= QDEPTH) begin
						r.status = ST_FULL;
					end else begin
						class_jobs[q] = {class_jobs[q], w.handle};
					end
				end
			end else begin
				found = 1'b0;
				if (class_jobs[CLS_IMPORTANT].size() != 0) begin
					r.handle = class_jobs[CLS_IMPORTANT].pop_front();
					found = 1'b1;
				end
				// preference walk, codes above misc mean none
				for (int i = 0; i < NUM_PREF; i++) begin
					q = w.prefs[i];
					if (!found && q < NCLS && class_jobs[q].size() != 0) begin
						r.handle = class_jobs[q].pop_front();
						r.queue  = q;
						found    = 1'b1;
					end
				end
				r.status = found ? ST_GRANT : ST_NOJOB;
			end
			owed = {owed, r};
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one result word with the oldest owed result
		task check(status_t st, logic [HANDLE_W-1:0] h, cls_t q);
			dispatch_result_t e;
			if (owed.size() == 0) begin
				report($sformatf("result with none owed: status %0d handle %h queue %0d",
					st, h, q));
				return;
			end
			e = owed.pop_front();
			if (st !== e.status)
				report($sformatf("status %0d, want %0d", st, e.status));
			if (h !== e.handle)
				report($sformatf("granted_handle %h, want %h", h, e.handle));
			if (q !== e.queue)
				report($sformatf("queue_used %0d, want %0d", q, e.queue));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [HANDLE_W-1:0] job_handle;
	logic [FLAG_W-1:0]   class_flags;
	logic [CLS_W-1:0]    pref_first;
	logic [CLS_W-1:0]    pref_second;
	logic [CLS_W-1:0]    pref_third;
	logic [CLS_W-1:0]    pref_fourth;
	logic [CLS_W-1:0]    pref_fifth;
	logic                out_valid;
	logic                out_stall;
	status_t             status;
	logic [HANDLE_W-1:0] granted_handle;
	logic [CLS_W-1:0]    queue_used;

	job_queue_tracker tracker = new;
	bit               calm;
	int               words_sent;

	typed_job_queue_dispatcher #(
		.QUEUE_DEPTH(QDEPTH),
		.HANDLE_BITS(HANDLE_W),
		.NUM_CLASSES(NCLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.job_handle(job_handle),
		.class_flags(class_flags),
		.pref_first(pref_first),
		.pref_second(pref_second),
		.pref_third(pref_third),
		.pref_fourth(pref_fourth),
		.pref_fifth(pref_fifth),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_handle(granted_handle),
		.queue_used(queue_used)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic job_word_t word_of(func_t fn, logic [HANDLE_W-1:0] h,
			logic [FLAG_W-1:0] f, pref_list_t p);
		job_word_t w;
		w.fn     = fn;
		w.handle = h;
		w.flags  = f;
		w.prefs  = p;
		return w;
	endfunction

	// Random word; submits lean towards one class so its queue overflows
	function automatic job_word_t random_word(int submit_pct, int focus);
		job_word_t w;
		w.fn = ($urandom_range(0, 99) < submit_pct) ? FN_SUBMIT : FN_REQUEST;
		case ($urandom_range(0, 19))
			0: w.handle = '0;
			1: w.handle = '1;
			default: w.handle = HANDLE_W'($urandom_range(1, 65535));
		endcase
		w.flags = FLAG_W'($urandom_range(0, 31));
		if ($urandom_range(0, 99) < 60) begin
			if (focus == CLS_MISC) begin
				w.flags = '0;
			end else begin
				w.flags = w.flags | (FLAG_W'(1) << focus);
				w.flags = w.flags & ~((FLAG_W'(1) << focus) - FLAG_W'(1));
			end
		end
		for (int i = 0; i < NUM_PREF; i++)
			w.prefs[i] = CLS_W'($urandom_range(0, 7));
		return w;
	endfunction

	// Present one word and hold it until the block takes it
	task automatic send_word(job_word_t w);
		while (!calm && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= w.fn;
		job_handle  <= w.handle;
		class_flags <= w.flags;
		pref_first  <= w.prefs[0];
		pref_second <= w.prefs[1];
		pref_third  <= w.prefs[2];
		pref_fourth <= w.prefs[3];
		pref_fifth  <= w.prefs[4];
		do @(posedge clk); while (in_stall);
		tracker.predict(w);
		words_sent++;
	endtask

	// Hold off input until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.owed.size() != 0);
	endtask

	// Result side: check accepted words, stall at random
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check(status, granted_handle, queue_used);
			out_stall <= !calm && ($urandom_range(0, 99) < 7);
		end
	end

	// Stimulus
	initial begin
		int rand_goal;
		int phase;
		int pct;
		int focus;
		int len;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FN_SUBMIT;
		job_handle  <= '0;
		class_flags <= '0;
		pref_first  <= '0;
		pref_second <= '0;
		pref_third  <= '0;
		pref_fourth <= '0;
		pref_fifth  <= '0;
		calm        = 1'b0;
		words_sent  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty request, null, one handle per class
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_IO, CLS_HUGE, CLS_GFX, CLS_TINY, CLS_MISC}));
		send_word(word_of(FN_SUBMIT, 16'h0000, 5'h1f, {5{PREF_NONE}}));
		send_word(word_of(FN_SUBMIT, 16'hffff, 5'h00, {5{PREF_SPARE}}));
		send_word(word_of(FN_SUBMIT, 16'h0001, 5'h1f, {5{PREF_NONE}}));
		send_word(word_of(FN_SUBMIT, 16'h8000, 5'h1e, {5{PREF_NONE}}));
		send_word(word_of(FN_SUBMIT, 16'h5555, 5'h1c, {5{PREF_NONE}}));
		send_word(word_of(FN_SUBMIT, 16'haaaa, 5'h18, {5{PREF_NONE}}));
		send_word(word_of(FN_SUBMIT, 16'h1234, 5'h10, {5{PREF_NONE}}));
		// important first even with every slot none
		send_word(word_of(FN_REQUEST, 16'hffff, 5'h1f,
			{PREF_NONE, PREF_SPARE, PREF_NONE, PREF_SPARE, PREF_NONE}));
		// important named again while empty, others not named
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_IMPORTANT, PREF_SPARE, PREF_NONE, CLS_IMPORTANT, PREF_NONE}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{PREF_NONE, PREF_SPARE, CLS_MISC, CLS_IO, CLS_HUGE}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_TINY, CLS_IO, CLS_HUGE, CLS_GFX, CLS_MISC}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{PREF_SPARE, CLS_GFX, CLS_IO, CLS_HUGE, CLS_MISC}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_HUGE, CLS_IO, PREF_NONE, PREF_NONE, PREF_NONE}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_IO, PREF_NONE, PREF_NONE, PREF_NONE, PREF_NONE}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{CLS_IO, CLS_HUGE, CLS_GFX, CLS_TINY, CLS_MISC}));
		// preference found only in the last slot
		send_word(word_of(FN_SUBMIT, 16'h7fff, 5'h02, {5{PREF_NONE}}));
		send_word(word_of(FN_REQUEST, 16'h0000, 5'h00,
			{PREF_NONE, PREF_NONE, PREF_SPARE, PREF_NONE, CLS_IO}));

		// random: fill, drain and mixed phases
		rand_goal = words_sent + RANDOM_WORDS;
		phase     = 0;
		while (words_sent < rand_goal) begin
			case (phase % 3)
				0: pct = 85;
				1: pct = 15;
				default: pct = 50;
			endcase
			focus = $urandom_range(0, NCLS - 1);
			len   = $urandom_range(20, 60);
			calm  = (phase >= 6 && phase < 10);
			repeat (len) send_word(random_word(pct, focus));
			if (phase == 4 || phase == 11)
				drain_results();
			phase++;
		end
		calm = 1'b0;

		// let the pipe empty, then wait idle to catch stray words
		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#400_000;
		$display("FAIL");
		$finish;
	end

endmodule
